// File: design/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types, constants and helpers for the go-to-goal dual PID core.
// ----------------------------------------------------------------------------
package gtg_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS + 1);

  localparam logic [1:0] REQ_POS     = 2'd0;
  localparam logic [1:0] REQ_HEADING = 2'd1;
  localparam logic [1:0] REQ_TICK    = 2'd2;

  localparam logic [2:0] REG_GOAL_X   = 3'd0;
  localparam logic [2:0] REG_GOAL_Y   = 3'd1;
  localparam logic [2:0] REG_LIN_P    = 3'd2;
  localparam logic [2:0] REG_LIN_I    = 3'd3;
  localparam logic [2:0] REG_LIN_D    = 3'd4;
  localparam logic [2:0] REG_ANG_P    = 3'd5;
  localparam logic [2:0] REG_ANG_I    = 3'd6;
  localparam logic [2:0] REG_ANG_D    = 3'd7;

  localparam logic signed [16:0] PI_Q13     = 17'sd25736;
  localparam logic signed [16:0] TWO_PI_Q13 = 17'sd51472;
  localparam logic signed [23:0] PI_Q16     = 24'sd205887;
  localparam logic [31:0]        NEAR_Q22   = 32'd419430;
  // ceil(2^36 / 10), exact for dividends below 2^34
  localparam logic signed [33:0] DIV10_MAGIC = 34'sh1_9999_999A;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading_in;
  } req_t;

  typedef struct packed {
    logic signed [31:0] linear_cmd;
    logic signed [31:0] angular_cmd;
    logic               reached;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_PID,
    ST_OUT
  } state_t;

  // atan(2^-i) in Q.16
  function automatic logic signed [23:0] atan_q16(input logic [4:0] i);
    logic signed [23:0] v;
    unique case (i)
      5'd0:  v = 24'sd51472;
      5'd1:  v = 24'sd30386;
      5'd2:  v = 24'sd16055;
      5'd3:  v = 24'sd8150;
      5'd4:  v = 24'sd4091;
      5'd5:  v = 24'sd2047;
      5'd6:  v = 24'sd1024;
      5'd7:  v = 24'sd512;
      5'd8:  v = 24'sd256;
      5'd9:  v = 24'sd128;
      5'd10: v = 24'sd64;
      5'd11: v = 24'sd32;
      5'd12: v = 24'sd16;
      5'd13: v = 24'sd8;
      5'd14: v = 24'sd4;
      5'd15: v = 24'sd2;
      5'd16: v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: design/gtg_sqrt.sv
// ----------------------------------------------------------------------------
// gtg_sqrt
// Bit-serial floor square root of a 63-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module gtg_sqrt import gtg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [62:0] n,
  output logic        done,
  output logic [31:0] root
);

  logic [62:0] rem;
  logic [63:0] res;
  logic [4:0]  k;
  logic        busy;
  logic [63:0] bitv;
  logic [63:0] trial;
  logic        fits;

  assign bitv  = 64'(1) << {k, 1'b0};
  assign trial = res + bitv;
  assign fits  = 64'(rem) >= trial;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= 5'd0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      k    <= 5'd31;
    end else if (busy) begin
      if (k == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        k <= k - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= n;
      res <= 64'd0;
    end else if (busy) begin
      if (fits) begin
        rem <= 63'(64'(rem) - trial);
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
    end
  end

endmodule

// File: design/gtg_cordic.sv
// ----------------------------------------------------------------------------
// gtg_cordic
// Iterative vectoring CORDIC, one micro-rotation a cycle, bearing in Q3.13.
// ----------------------------------------------------------------------------
module gtg_cordic import gtg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] x_in,
  input  logic signed [32:0] y_in,
  output logic               done,
  output logic signed [15:0] angle
);

  logic signed [35:0]       cx;
  logic signed [35:0]       cy;
  logic signed [23:0]       cz;
  logic [CORDIC_CNT_W-1:0]  cnt;
  logic                     busy;
  logic                     zero_in;
  logic signed [35:0]       sx;
  logic signed [35:0]       sy;
  logic signed [23:0]       az;
  logic signed [23:0]       rz;

  assign zero_in = (x_in == 33'sd0) && (y_in == 33'sd0);
  assign sx      = cx >>> cnt;
  assign sy      = cy >>> cnt;
  assign az      = atan_q16(5'(cnt));
  assign rz      = (cz + 24'sd4) >>> 3;

  always_comb begin
    if (rz > 24'(PI_Q13)) angle = 16'(PI_Q13);
    else if (rz < -24'(PI_Q13)) angle = 16'(-PI_Q13);
    else angle = rz[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= !zero_in;
      done <= zero_in;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (zero_in) begin
        cx <= '0;
        cy <= '0;
        cz <= '0;
      end else if (x_in < 0) begin
        cx <= -36'(x_in);
        cy <= -36'(y_in);
        cz <= (y_in >= 0) ? PI_Q16 : -PI_Q16;
      end else begin
        cx <= 36'(x_in);
        cy <= 36'(y_in);
        cz <= '0;
      end
    end else if (busy) begin
      if (cy >= 0) begin
        cx <= cx + sy;
        cy <= cy - sx;
        cz <= cz + az;
      end else begin
        cx <= cx - sy;
        cy <= cy + sx;
        cz <= cz - az;
      end
    end
  end

endmodule

// File: design/go_to_goal_dual_pid_core.sv
// ----------------------------------------------------------------------------
// go_to_goal_dual_pid_core
// Go-to-goal controller: distance and bearing to a target, two PID loops.
// ----------------------------------------------------------------------------
// Position and heading beats are only stored. A tick beat computes the
// squared offsets, then the bit-serial square root (32 steps; the CORDIC runs
// beside it), then uses the shared 34x34 multiplier for the integral updates
// and the six gain products, and then loads the result register once it is
// free. Input ready is low during a tick. A finished result waits in the
// output register while the next position or heading beat is taken.
module go_to_goal_dual_pid_core import gtg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [3:0] SQ_X    = 4'd0;
  localparam logic [3:0] SQ_Y    = 4'd1;
  localparam logic [3:0] SQ_SUM  = 4'd2;
  localparam logic [3:0] P_QD    = 4'd0;
  localparam logic [3:0] P_QH    = 4'd1;
  localparam logic [3:0] P_HI    = 4'd2;
  localparam logic [3:0] P_LP    = 4'd3;
  localparam logic [3:0] P_LI    = 4'd4;
  localparam logic [3:0] P_LD10  = 4'd5;
  localparam logic [3:0] P_LD    = 4'd6;
  localparam logic [3:0] P_LOUT  = 4'd7;
  localparam logic [3:0] P_AI    = 4'd8;
  localparam logic [3:0] P_AD10  = 4'd9;
  localparam logic [3:0] P_AD    = 4'd10;
  localparam logic [3:0] P_AOUT  = 4'd11;

  logic signed [31:0] goal_x, goal_y;
  logic [15:0] lin_p_gain, lin_i_gain, lin_d_gain;
  logic [15:0] ang_p_gain, ang_i_gain, ang_d_gain;

  logic signed [31:0] cur_x, cur_y;
  logic signed [15:0] cur_heading;
  logic [31:0]        last_dist_error;
  logic signed [15:0] last_heading_error;
  logic [31:0]        dist_integral;
  logic signed [31:0] heading_integral;

  state_t     state, state_next;
  logic [3:0] step, step_next;

  logic signed [32:0] dx, dy;
  logic [62:0]        sq_x;
  logic [31:0]        distance;
  logic signed [16:0] err;
  logic [31:0]        di;
  logic signed [31:0] hi;
  logic signed [67:0] prod;
  logic signed [63:0] acc;
  logic signed [31:0] lin;
  logic signed [31:0] ang;

  logic signed [33:0] ma, mb;
  logic [32:0]        abs_dx, abs_dy;
  logic [16:0]        abs_err;
  logic signed [32:0] diff_d;
  logic signed [17:0] diff_h;
  logic [31:0]        quo;
  logic [32:0]        di_sum;
  logic signed [32:0] quo_s;
  logic signed [33:0] hi_sum;
  logic signed [16:0] err_raw;
  logic signed [16:0] err_wrap;
  logic [31:0]        root;
  logic signed [15:0] bearing;
  logic               sqrt_done, cordic_done;
  logic               sqrt_start, cordic_start;
  logic               req_beat, load;

  assign cfg_ready    = 1'b1;
  assign req_beat     = req_valid && req_ready;
  assign load         = (state == ST_OUT) && (!rsp_valid || rsp_ready);
  assign sqrt_start   = (state == ST_SQ) && (step == SQ_SUM);
  assign cordic_start = (state == ST_SQ) && (step == SQ_X);

  assign abs_dx  = dx[32] ? 33'(-dx) : 33'(dx);
  assign abs_dy  = dy[32] ? 33'(-dy) : 33'(dy);
  assign abs_err = err[16] ? 17'(-err) : 17'(err);
  assign diff_d  = $signed({1'b0, distance}) - $signed({1'b0, last_dist_error});
  assign diff_h  = 18'(err) - 18'(last_heading_error);
  assign quo     = prod[67:36];
  assign di_sum  = {1'b0, dist_integral} + {1'b0, quo};
  assign quo_s   = err[16] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign hi_sum  = 34'(heading_integral) + 34'(quo_s);
  assign err_raw = 17'(bearing) - 17'(cur_heading);

  always_comb begin
    if (err_raw > PI_Q13) err_wrap = err_raw - TWO_PI_Q13;
    else if (err_raw < -PI_Q13) err_wrap = err_raw + TWO_PI_Q13;
    else err_wrap = err_raw;
  end

  gtg_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sqrt_start),
    .n    (sq_x + prod[62:0]),
    .done (sqrt_done),
    .root (root)
  );

  gtg_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(cordic_start),
    .x_in (dx),
    .y_in (dy),
    .done (cordic_done),
    .angle(bearing)
  );

  // sequencer
  always_comb begin
    state_next = state;
    step_next  = 4'd0;
    req_ready  = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (req_valid && req.req_type == REQ_TICK) state_next = ST_SQ;
      end
      ST_SQ: begin
        if (step == SQ_SUM) state_next = ST_ROOT;
        else step_next = step + 4'd1;
      end
      ST_ROOT: begin
        if (sqrt_done && cordic_done) state_next = ST_PID;
      end
      ST_PID: begin
        if (step == P_AOUT) state_next = ST_OUT;
        else step_next = step + 4'd1;
      end
      ST_OUT: begin
        if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= 4'd0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    if (state == ST_SQ) begin
      unique case (step)
        SQ_X: begin
          ma = 34'(abs_dx[32:1]);
          mb = 34'(abs_dx[32:1]);
        end
        SQ_Y: begin
          ma = 34'(abs_dy[32:1]);
          mb = 34'(abs_dy[32:1]);
        end
        default: ;
      endcase
    end else if (state == ST_PID) begin
      unique case (step)
        P_QD: begin
          ma = 34'({1'b0, distance} + 33'd5);
          mb = DIV10_MAGIC;
        end
        P_QH: begin
          ma = 34'({1'b0, abs_err} + 18'd5);
          mb = DIV10_MAGIC;
        end
        P_HI: begin
          ma = 34'(distance);
          mb = 34'(lin_p_gain);
        end
        P_LP: begin
          ma = 34'(di);
          mb = 34'(lin_i_gain);
        end
        P_LI: begin
          ma = 34'(diff_d);
          mb = 34'(lin_d_gain);
        end
        P_LD: begin
          ma = 34'(err);
          mb = 34'(ang_p_gain);
        end
        P_LOUT: begin
          ma = 34'(hi);
          mb = 34'(ang_i_gain);
        end
        P_AI: begin
          ma = 34'(diff_h);
          mb = 34'(ang_d_gain);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PID && (step == P_LD10 || step == P_AD10)) begin
      prod <= (prod <<< 3) + (prod <<< 1);
    end else begin
      prod <= ma * mb;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_beat) begin
      dx <= 33'(goal_x) - 33'(cur_x);
      dy <= 33'(goal_y) - 33'(cur_y);
    end
    if (state == ST_SQ && step == SQ_Y) sq_x <= prod[62:0];
    if (state == ST_ROOT && sqrt_done && cordic_done) begin
      distance <= root[31] ? 32'hFFFF_FFFF : {root[30:0], 1'b0};
      err      <= err_wrap;
    end
    if (state == ST_PID) begin
      unique case (step)
        P_QH:   di <= di_sum[32] ? 32'hFFFF_FFFF : di_sum[31:0];
        P_HI:   hi <= sat32(64'(hi_sum));
        P_LP:   acc <= prod[63:0];
        P_LI:   acc <= acc + prod[63:0];
        P_LD:   acc <= acc + prod[63:0];
        P_LOUT: begin
          lin <= sat32((acc + 64'sd8192) >>> 14);
          acc <= prod[63:0];
        end
        P_AI:   acc <= acc + prod[63:0];
        P_AD:   acc <= acc + prod[63:0];
        P_AOUT: ang <= sat32((acc + 64'sd16) >>> 5);
        default: ;
      endcase
    end
  end

  // registers and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x             <= '0;
      goal_y             <= '0;
      lin_p_gain         <= 16'd256;
      lin_i_gain         <= 16'd0;
      lin_d_gain         <= 16'd0;
      ang_p_gain         <= 16'd256;
      ang_i_gain         <= 16'd0;
      ang_d_gain         <= 16'd0;
      cur_x              <= '0;
      cur_y              <= '0;
      cur_heading        <= '0;
      last_dist_error    <= '0;
      last_heading_error <= '0;
      dist_integral      <= '0;
      heading_integral   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_GOAL_X:   goal_x     <= cfg_data;
          REG_GOAL_Y:   goal_y     <= cfg_data;
          REG_LIN_P:    lin_p_gain <= cfg_data[15:0];
          REG_LIN_I:    lin_i_gain <= cfg_data[15:0];
          REG_LIN_D:    lin_d_gain <= cfg_data[15:0];
          REG_ANG_P:    ang_p_gain <= cfg_data[15:0];
          REG_ANG_I:    ang_i_gain <= cfg_data[15:0];
          REG_ANG_D:    ang_d_gain <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (req_beat && req.req_type == REQ_POS) begin
        cur_x <= req.pos_x;
        cur_y <= req.pos_y;
      end
      if (req_beat && req.req_type == REQ_HEADING) cur_heading <= req.heading_in;
      if (state == ST_PID && step == P_AOUT) begin
        dist_integral      <= di;
        heading_integral   <= hi;
        last_dist_error    <= distance;
        last_heading_error <= err[15:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.reached     <= (distance <= NEAR_Q22);
      rsp.linear_cmd  <= (distance <= NEAR_Q22) ? 32'sd0 : lin;
      rsp.angular_cmd <= (distance <= NEAR_Q22) ? 32'sd0 : ang;
    end
  end

`ifndef SYNTHESIS
  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    req_beat && req.req_type == REQ_TICK |=> state == ST_SQ)
    else $error("tick beat did not start the sequence");

  a_reached_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.reached |-> rsp.linear_cmd == 32'sd0 && rsp.angular_cmd == 32'sd0)
    else $error("reached result carries nonzero commands");

  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_OUT))
    else $error("result raised outside the output state");

  a_no_beat_busy: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROOT |=> state == ST_ROOT || state == ST_PID)
    else $error("sequencer left the root wait illegally");
`endif

endmodule

// File: tb/tb_go_to_goal_dual_pid_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_go_to_goal_dual_pid_core
// Self-checking bench for the go-to-goal dual PID core: a directed table of
// requests, then randomized move/turn/tick traffic over several gain and
// target settings, every tick result compared against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_go_to_goal_dual_pid_core;
  import gtg_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #5 clk = ~clk;

  go_to_goal_dual_pid_core u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and loop state
  logic signed [31:0] m_tx, m_ty, m_cx, m_cy;
  logic [15:0]        m_gain [0:5];
  logic signed [15:0] m_head, m_last_herr;
  logic [31:0]        m_last_dist, m_dist_int;
  logic signed [31:0] m_head_int;

  rsp_t   cmd_q [$];
  int     errors = 0;
  int     n_items = 0, n_ticks = 0, n_near = 0, n_cfg = 0;
  bit     no_idle = 1'b0;

  function automatic longint shr_floor(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint cordic_bearing(longint x, longint y);
    longint z, nx, ny, r;
    longint angs [0:16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2, 1};
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 205887 : -205887;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + shr_floor(y, i);
        ny = y - shr_floor(x, i);
        z += (i <= 16) ? angs[i] : 0;
      end else begin
        nx = x - shr_floor(y, i);
        ny = y + shr_floor(x, i);
        z -= (i <= 16) ? angs[i] : 0;
      end
      x = nx;
      y = ny;
    end
    r = shr_floor(z + 4, 3);
    if (r > 25736) r = 25736;
    if (r < -25736) r = -25736;
    return r;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint div_by_ten(longint v);
    if (v >= 0) return (v + 5) / 10;
    return -((-v + 5) / 10);
  endfunction

  function automatic void write_reg_model(logic [2:0] idx, logic [31:0] d);
    case (idx)
      REG_GOAL_X: m_tx = d;
      REG_GOAL_Y: m_ty = d;
      default: m_gain[idx - 2] = d[15:0];
    endcase
  endfunction

  // apply one request to the predictor, queue the command it yields
  function automatic void steer_predict(req_t r);
    longint dx, dy, err, derr, bear, lin, ang, hi;
    longint unsigned ax, ay, distance, di;
    rsp_t e;
    case (r.req_type)
      REQ_POS: begin
        m_cx = r.pos_x;
        m_cy = r.pos_y;
      end
      REQ_HEADING: m_head = r.heading_in;
      REQ_TICK: begin
        dx = longint'(m_tx) - longint'(m_cx);
        dy = longint'(m_ty) - longint'(m_cy);
        ax = (dx < 0 ? -dx : dx) >> 1;
        ay = (dy < 0 ? -dy : dy) >> 1;
        distance = floor_sqrt(ax * ax + ay * ay) << 1;
        if (distance > 64'hFFFF_FFFF) distance = 64'hFFFF_FFFF;
        bear = cordic_bearing(dx, dy);
        err = bear - longint'(m_head);
        if (err > 25736) err -= 51472;
        else if (err < -25736) err += 51472;
        di = longint'(m_dist_int) + (distance + 5) / 10;
        if (di > 64'hFFFF_FFFF) di = 64'hFFFF_FFFF;
        m_dist_int = di[31:0];
        lin = longint'(m_gain[0]) * longint'(distance) + longint'(m_gain[1]) * longint'(di)
            + longint'(m_gain[2]) * ((longint'(distance) - longint'(m_last_dist)) * 10);
        lin = clamp32(shr_floor(lin + 8192, 14));
        m_last_dist = distance[31:0];
        hi = clamp32(longint'(m_head_int) + div_by_ten(err));
        m_head_int = hi[31:0];
        derr = (err - longint'(m_last_herr)) * 10;
        ang = longint'(m_gain[3]) * err + longint'(m_gain[4]) * hi
            + longint'(m_gain[5]) * derr;
        ang = clamp32(shr_floor(ang + 16, 5));
        m_last_herr = err[15:0];
        e.reached = (distance <= NEAR_Q22);
        e.linear_cmd = e.reached ? 32'sd0 : lin[31:0];
        e.angular_cmd = e.reached ? 32'sd0 : ang[31:0];
        cmd_q.push_back(e);
        n_ticks++;
        if (e.reached) n_near++;
      end
      default: ;
    endcase
  endfunction

  task automatic idle_gap();
    while (!no_idle && $urandom_range(99) < 18) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // leaves valid high at the falling edge after the beat; the caller either
  // sends the next beat or drops valid in the same time step
  task automatic send_req(req_t r);
    idle_gap();
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    steer_predict(r);
    n_items++;
    @(negedge clk);
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    write_reg_model(idx, d);
    n_cfg++;
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (cmd_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // response side: random backpressure, compare each beat
  always @(negedge clk) begin
    if (!rst) rsp_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (cmd_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected command beat %h", rsp);
      end else begin
        e = cmd_q.pop_front();
        if (rsp.linear_cmd !== e.linear_cmd || rsp.angular_cmd !== e.angular_cmd ||
            rsp.reached !== e.reached) begin
          errors++;
          if (errors <= 10)
            $display("mismatch lin %h/%h ang %h/%h reached %b/%b",
                     e.linear_cmd, rsp.linear_cmd, e.angular_cmd, rsp.angular_cmd,
                     e.reached, rsp.reached);
        end
      end
    end
  end

  function automatic req_t mk(logic [1:0] t, logic [31:0] x, logic [31:0] y,
                              logic [15:0] h);
    req_t r;
    r.req_type = t;
    r.pos_x = x;
    r.pos_y = y;
    r.heading_in = h;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1_000_000) - 500_000;
      default: return $signed($urandom_range(40_000_000)) - 32'sd20_000_000;
    endcase
  endfunction

  function automatic logic [15:0] rand_heading();
    if ($urandom_range(9) == 0) return $urandom();
    return $signed($urandom_range(51472)) - 16'sd25736;
  endfunction

  // directed table; expectation typed in only where it is obvious
  typedef struct {
    req_t r;
    bit   chk;
    rsp_t exp;
  } row_t;

  initial begin
    row_t rows [$];
    req_t r;
    rsp_t zero_near;
    int   mode;
    zero_near = '{linear_cmd: 32'sd0, angular_cmd: 32'sd0, reached: 1'b1};
    m_tx = 0; m_ty = 0; m_cx = 0; m_cy = 0; m_head = 0;
    m_gain = '{256, 0, 0, 256, 0, 0};
    m_last_dist = 0; m_last_herr = 0; m_dist_int = 0; m_head_int = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rows.push_back('{mk(REQ_TICK, 0, 0, 0), 1, zero_near});
    rows.push_back('{mk(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF), 0, '0});
    rows.push_back('{mk(REQ_TICK, 0, 0, 0), 1, zero_near});
    rows.push_back('{mk(REQ_POS, 32'h7FFF_FFFF, 32'h8000_0000, 0), 0, '0});
    rows.push_back('{mk(REQ_TICK, 0, 0, 0), 0, '0});
    rows.push_back('{mk(REQ_POS, 32'h8000_0000, 32'h7FFF_FFFF, 0), 0, '0});
    rows.push_back('{mk(REQ_HEADING, 0, 0, 16'sd25736), 0, '0});
    rows.push_back('{mk(REQ_TICK, 0, 0, 0), 0, '0});
    rows.push_back('{mk(REQ_HEADING, 0, 0, -16'sd25736), 0, '0});
    rows.push_back('{mk(REQ_TICK, 0, 0, 0), 0, '0});
    rows.push_back('{mk(REQ_HEADING, 0, 0, 16'h7FFF), 0, '0});
    rows.push_back('{mk(REQ_POS, -32'sd4194304, 32'sd1, 0), 0, '0});
    rows.push_back('{mk(REQ_TICK, 0, 0, 0), 0, '0});
    rows.push_back('{mk(REQ_HEADING, 0, 0, 16'h8000), 0, '0});
    rows.push_back('{mk(REQ_POS, -32'sd4194304, -32'sd1, 0), 0, '0});
    rows.push_back('{mk(REQ_TICK, 0, 0, 0), 0, '0});
    rows.push_back('{mk(REQ_POS, 32'sd419430, 0, 0), 0, '0});
    rows.push_back('{mk(REQ_TICK, 0, 0, 0), 1, zero_near});
    rows.push_back('{mk(REQ_POS, 32'sd419432, 0, 0), 0, '0});
    rows.push_back('{mk(REQ_TICK, 0, 0, 0), 0, '0});
    rows.push_back('{mk(REQ_POS, 0, 0, 0), 0, '0});
    rows.push_back('{mk(REQ_TICK, 0, 0, 0), 1, zero_near});

    foreach (rows[i]) begin
      send_req(rows[i].r);
      if (rows[i].chk && cmd_q.size() > 0 && cmd_q[$] !== rows[i].exp) begin
        errors++;
        if (errors <= 10) $display("row %0d: predictor disagrees with table", i);
      end
    end
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      // register settings: extremes on the first two phases, random targets later and random gains from the fourth
      for (int k = 0; k < 8; k++) begin
        logic [31:0] d;
        case (ph)
          0: d = (k < 2) ? 32'h7FFF_FFFF : 32'h0000_FFFF;
          1: d = (k < 2) ? 32'h8000_0000 : 32'h0;
          2: d = (k < 2) ? rand_coord() : 32'h0000_0100;
          default: d = (k < 2) ? rand_coord() : $urandom_range(1023);
        endcase
        write_reg(k[2:0], d);
      end
      cfg_valid <= 1'b0;
      no_idle = (ph == 3);
      for (int n = 0; n < 150; n++) begin
        mode = $urandom_range(99);
        if (mode < 40) r = mk(REQ_TICK, $urandom(), $urandom(), $urandom());
        else if (mode < 65) r = mk(REQ_POS, rand_coord(), rand_coord(), $urandom());
        else if (mode < 85) r = mk(REQ_HEADING, $urandom(), $urandom(), rand_heading());
        else if (mode < 95) begin
          r = mk(REQ_POS, m_tx + $signed($urandom_range(800_000)) - 32'sd400_000,
                 m_ty + $signed($urandom_range(800_000)) - 32'sd400_000, 0);
        end else r = mk(2'd3, $urandom(), $urandom(), $urandom());
        send_req(r);
        if (n == 75) begin
          req_valid <= 1'b0;
          do @(negedge clk); while (cmd_q.size() != 0);
        end
      end
      no_idle = 1'b0;
      drain();
    end

    $display("covered %0d requests, %0d ticks (%0d at goal), %0d register writes",
             n_items, n_ticks, n_near, n_cfg);
    if (errors == 0 && cmd_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d commands missing", errors, cmd_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: go_to_goal_dual_pid_core.f
design/gtg_pkg.sv
design/gtg_sqrt.sv
design/gtg_cordic.sv
design/go_to_goal_dual_pid_core.sv
tb/tb_go_to_goal_dual_pid_core.sv
